### rtl/rc4_stream_cipher_assert.svh
// Assertion macros shared by the cipher's checker.
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, idle during reset.
`define RC4_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Implication with a fixed delay of dly cycles.
`define RC4_ASSERT_DELAY(label, ante, dly, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

### rtl/rc4_pkg.sv
// Shared types and constants of the RC4 cipher block.
package rc4_pkg;

   localparam int BYTE_W     = 8;
   localparam int PERM_DEPTH = 256;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int KEY_LEN_W  = 4;

   // Item kinds.
   localparam logic KIND_RESTART = 1'b0;
   localparam logic KIND_DATA    = 1'b1;

   // Register index (address bit 3).
   localparam logic REG_KEY_BYTES  = 1'b0;
   localparam logic REG_KEY_LENGTH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_J,
      ST_RD_T,
      ST_FIN,
      ST_KS_RD,
      ST_KS_W1,
      ST_KS_W2
   } rc4_state_type;

endpackage

### rtl/rc4_ram.sv
// Generic single-write, single-read RAM with a registered, read-first read port.
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/rc4_stream_cipher.sv
// RC4 stream cipher: key schedule, keystream generation and byte XOR around one RAM.
// A data beat's result is registered as it leaves ST_FIN, which waits for a free result register.
// New beats enter in idle or as the last one finishes, set by the RAM's single read and write port.
// A restart beat runs the key schedule over all 256 entries and gives no result.
// Reset is synchronous: the permutation reads as identity, indices zero, key 0 of length 1.
module rc4_stream_cipher #(
   parameter int MAX_KEY_BYTES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input channel.
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic [rc4_pkg::BYTE_W-1:0]      req_data_in,
   // Result channel.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rc4_pkg::BYTE_W-1:0]      rsp_data_out,
   // Configuration port.
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rc4_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rc4_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rc4_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int BW  = rc4_pkg::BYTE_W;
   localparam int AW  = $clog2(rc4_pkg::PERM_DEPTH);
   localparam int KLW = rc4_pkg::KEY_LEN_W;
   // Width of the key byte position counter.
   localparam int KPW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam logic [KLW-1:0] MAX_LEN = KLW'(MAX_KEY_BYTES);

   // ------------------------------------------------------------------
   // Configuration registers. The register index is address bit 3, so
   // the two 64-bit registers sit at byte addresses 0 and 8.
   // ------------------------------------------------------------------
   logic [rc4_pkg::CSR_DATA_W-1:0] key_bytes_ff, key_bytes_in;
   logic [KLW-1:0]                 key_length_ff, key_length_in;
   logic                           csr_write;
   logic                           csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      key_bytes_in  = key_bytes_ff;
      key_length_in = key_length_ff;
      if (csr_write) begin
         if (csr_index == rc4_pkg::REG_KEY_BYTES) begin
            key_bytes_in = csr_pwdata;
         end else begin
            key_length_in = csr_pwdata[KLW-1:0];
         end
      end
   end

   assign csr_prdata = (csr_index == rc4_pkg::REG_KEY_LENGTH) ?
                       rc4_pkg::CSR_DATA_W'(key_length_ff) : key_bytes_ff;

   // ------------------------------------------------------------------
   // Permutation RAM. The memory itself is never cleared. A per-entry
   // valid bit marks entries written since the last reset or restart;
   // an entry without it reads as its own address, which is exactly the
   // identity permutation that both reset and the key schedule start from.
   // ------------------------------------------------------------------
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [BW-1:0] mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [BW-1:0] mem_rdata;

   rc4_ram #(
      .WIDTH (BW),
      .DEPTH (rc4_pkg::PERM_DEPTH)
   ) u_perm_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   logic [rc4_pkg::PERM_DEPTH-1:0] valid_ff, valid_in;
   logic                           valid_clear;
   // Valid bit and address captured with each read, so the read data can
   // be replaced by the identity value when the entry was never written.
   logic                           rd_valid_ff, rd_valid_in;
   logic [AW-1:0]                  rd_addr_ff, rd_addr_in;
   logic [BW-1:0]                  rd_value;

   assign rd_value = rd_valid_ff ? mem_rdata : rd_addr_ff;

   always_comb begin
      valid_in = valid_ff;
      if (valid_clear) begin
         valid_in = '0;
      end else if (mem_we) begin
         valid_in[mem_waddr] = 1'b1;
      end
      rd_valid_in = rd_valid_ff;
      rd_addr_in  = rd_addr_ff;
      if (mem_re) begin
         rd_valid_in = valid_ff[mem_raddr];
         rd_addr_in  = mem_raddr;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer state and working registers.
   // ------------------------------------------------------------------
   rc4_pkg::rc4_state_type state_ff, state_in;

   logic [BW-1:0]  i_ff, i_in;        // index_i, already advanced for the beat in flight
   logic [BW-1:0]  j_ff, j_in;        // index_j
   logic [BW-1:0]  si_ff, si_in;      // S[i] of a data beat, or S[n] in the key schedule
   logic [BW-1:0]  sj_ff, sj_in;      // S[j] of a data beat
   logic [BW-1:0]  data_ff, data_in;  // data byte of the beat in flight
   logic [AW-1:0]  n_ff, n_in;        // key schedule entry counter
   logic [BW-1:0]  acc_ff, acc_in;    // key schedule running index
   logic [KPW-1:0] kpos_ff, kpos_in;  // key byte position, cycles through the key length

   // The RAM reads old data when a read meets a write to the same entry in
   // one cycle. Such collisions are known at issue time, so the value being
   // written is kept here and replaces the stale read data when it arrives.
   logic           fwd_hit_ff, fwd_hit_in;
   logic [BW-1:0]  fwd_val_ff, fwd_val_in;
   // The keystream read S[t] overlaps the swap: S[i] is written in the
   // same cycle and S[j] in the cycle after, so both are matched against t.
   logic           hit_i_ff, hit_i_in;
   logic           hit_j_ff, hit_j_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]  rsp_data_ff, rsp_data_in;

   logic           out_free;
   logic [BW-1:0]  first_value;
   logic [KLW-1:0] eff_len;
   logic [KLW-1:0] eff_len_m1;
   logic [BW-1:0]  key_byte;
   logic [BW-1:0]  next_i;
   logic [BW-1:0]  j_next;
   logic [BW-1:0]  t_addr;
   logic [BW-1:0]  acc_next;
   logic [BW-1:0]  keystream;

   // The result register frees up when it is empty or being taken now.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // First read of a step: forwarded value if it collided with a write.
   assign first_value = fwd_hit_ff ? fwd_val_ff : rd_value;

   // A key length of zero acts as one; lengths above the maximum saturate.
   always_comb begin
      if (key_length_ff == '0) begin
         eff_len = KLW'(1);
      end else if (key_length_ff > MAX_LEN) begin
         eff_len = MAX_LEN;
      end else begin
         eff_len = key_length_ff;
      end
   end
   assign eff_len_m1 = eff_len - KLW'(1);

   assign key_byte  = key_bytes_ff[{kpos_ff, 3'b000} +: BW];
   assign next_i    = i_ff + BW'(1);
   assign j_next    = j_ff + first_value;
   assign t_addr    = si_ff + rd_value;
   assign acc_next  = acc_ff + first_value + key_byte;
   assign keystream = hit_j_ff ? si_ff : (hit_i_ff ? sj_ff : rd_value);

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      data_in      = data_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      kpos_in      = kpos_ff;
      fwd_hit_in   = fwd_hit_ff;
      fwd_val_in   = fwd_val_ff;
      hit_i_in     = hit_i_ff;
      hit_j_in     = hit_j_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      valid_clear  = 1'b0;

      case (state_ff)
         rc4_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         rc4_pkg::ST_RD_J: begin
            // S[i] is here: advance j and fetch S[j].
            si_in      = first_value;
            j_in       = j_next;
            mem_re     = 1'b1;
            mem_raddr  = j_next;
            fwd_hit_in = 1'b0;
            state_in   = rc4_pkg::ST_RD_T;
         end
         rc4_pkg::ST_RD_T: begin
            // S[j] is here: first half of the swap, then fetch S[S[i]+S[j]].
            sj_in     = rd_value;
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = rd_value;
            mem_re    = 1'b1;
            mem_raddr = t_addr;
            hit_i_in  = (t_addr == i_ff);
            hit_j_in  = (t_addr == j_ff);
            state_in  = rc4_pkg::ST_FIN;
         end
         rc4_pkg::ST_FIN: begin
            // Second half of the swap. It is repeated harmlessly while the
            // result register is still occupied.
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = si_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = data_ff ^ keystream;
               req_ready    = 1'b1;
               state_in     = rc4_pkg::ST_IDLE;
            end
         end
         rc4_pkg::ST_KS_RD: begin
            // S[n] is here: step the running index and fetch S[acc].
            si_in     = first_value;
            acc_in    = acc_next;
            mem_re    = 1'b1;
            mem_raddr = acc_next;
            state_in  = rc4_pkg::ST_KS_W1;
         end
         rc4_pkg::ST_KS_W1: begin
            mem_we    = 1'b1;
            mem_waddr = n_ff;
            mem_wdata = rd_value;
            state_in  = rc4_pkg::ST_KS_W2;
         end
         rc4_pkg::ST_KS_W2: begin
            // Finish the swap and, unless this was the last entry, fetch the
            // next one in the same cycle.
            mem_we    = 1'b1;
            mem_waddr = acc_ff;
            mem_wdata = si_ff;
            if (KLW'(kpos_ff) == eff_len_m1) begin
               kpos_in = '0;
            end else begin
               kpos_in = kpos_ff + KPW'(1);
            end
            if (n_ff == AW'(rc4_pkg::PERM_DEPTH - 1)) begin
               i_in     = '0;
               j_in     = '0;
               state_in = rc4_pkg::ST_IDLE;
            end else begin
               n_in       = n_ff + AW'(1);
               mem_re     = 1'b1;
               mem_raddr  = n_ff + AW'(1);
               fwd_hit_in = ((n_ff + AW'(1)) == acc_ff);
               fwd_val_in = si_ff;
               state_in   = rc4_pkg::ST_KS_RD;
            end
         end
         default: begin
            state_in = rc4_pkg::ST_IDLE;
         end
      endcase

      // Start of a new beat, taken in idle or while the last one finishes.
      if (req_valid && req_ready) begin
         if (req_kind == rc4_pkg::KIND_DATA) begin
            i_in       = next_i;
            data_in    = req_data_in;
            mem_re     = 1'b1;
            mem_raddr  = next_i;
            fwd_hit_in = mem_we && (mem_waddr == next_i);
            fwd_val_in = mem_wdata;
            state_in   = rc4_pkg::ST_RD_J;
         end else begin
            // Restart: all entries fall back to identity at once, so entry 0
            // reads as zero regardless of what the RAM returns.
            valid_clear = 1'b1;
            n_in        = '0;
            acc_in      = '0;
            kpos_in     = '0;
            mem_re      = 1'b1;
            mem_raddr   = '0;
            fwd_hit_in  = 1'b1;
            fwd_val_in  = '0;
            state_in    = rc4_pkg::ST_KS_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rc4_pkg::ST_IDLE;
         i_ff          <= '0;
         j_ff          <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         fwd_hit_ff    <= 1'b0;
         key_bytes_ff  <= '0;
         key_length_ff <= KLW'(1);
      end else begin
         state_ff      <= state_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fwd_hit_ff    <= fwd_hit_in;
         key_bytes_ff  <= key_bytes_in;
         key_length_ff <= key_length_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      data_ff     <= data_in;
      n_ff        <= n_in;
      acc_ff      <= acc_in;
      kpos_ff     <= kpos_in;
      fwd_val_ff  <= fwd_val_in;
      hit_i_ff    <= hit_i_in;
      hit_j_ff    <= hit_j_in;
      rd_valid_ff <= rd_valid_in;
      rd_addr_ff  <= rd_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;

endmodule

### rtl/rc4_checker.sv
// Port-level checker for the RC4 cipher, bound to the top level.
`include "rc4_stream_cipher_assert.svh"

module rc4_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_kind,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [rc4_pkg::BYTE_W-1:0] rsp_data_out
);

   logic data_beat;
   logic req_beat;

   assign req_beat  = req_valid && req_ready;
   assign data_beat = req_beat && (req_kind == rc4_pkg::KIND_DATA);

   // A waiting result holds until it is taken.
   `RC4_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_out), "result changed while stalled")

   // Every beat keeps the block busy for at least the following cycle.
   `RC4_ASSERT_NEXT(a_busy_after_beat, req_beat, !req_ready, "input ready right after a beat")

   // A data beat has a result waiting once it has passed ST_RD_J, ST_RD_T and ST_FIN.
   `RC4_ASSERT_DELAY(a_data_result, data_beat, 4, rsp_valid, "no result after a data beat")

   // A fresh result only appears as a data beat leaves ST_FIN.
   `RC4_ASSERT_SAME(a_no_spurious, $rose(rsp_valid), $past(data_beat, 4), "result without a data beat")

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);

### dv/testbench.sv
// Self-checking testbench for the RC4 stream cipher block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_BYTES_MAX = 8;
   // A restart beat keeps the block busy through its whole key schedule without any
   // result, so every register write and the end of the run wait out a full key
   // schedule once the result queue has drained.
   localparam int KEY_SCHEDULE_SETTLE = 800;
   localparam int CYCLE_LIMIT = 1_000_000;
   // Each side leaves a cycle empty with this chance, in percent.
   localparam int IDLE_PERCENT = 26;

   typedef struct packed {
      logic                       kind;
      logic [rc4_pkg::BYTE_W-1:0] data;
   } cipher_beat_type;

   // Clock, reset and all block inputs hold known values from time zero.
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_kind = rc4_pkg::KIND_DATA;
   logic [rc4_pkg::BYTE_W-1:0]     req_data_in = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [rc4_pkg::BYTE_W-1:0]     rsp_data_out;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [rc4_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [rc4_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [rc4_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // Beats waiting for the driver, and cipher bytes waiting for the block to return them.
   cipher_beat_type            pending_beats[$];
   logic [rc4_pkg::BYTE_W-1:0] cipher_bytes_due[$];

   // Set at a rising edge when the input beat on the bus was taken there.
   logic req_taken = 1'b0;
   // While set, neither side inserts idle cycles.
   bit   no_gaps = 1'b0;

   int fail_count = 0;
   int bytes_checked = 0;
   int restarts_seen = 0;
   int key_settings = 0;
   int cycle_count = 0;

   // Our own copy of the cipher state and of the two configuration registers.
   logic [rc4_pkg::BYTE_W-1:0]    sbox [rc4_pkg::PERM_DEPTH];
   logic [rc4_pkg::BYTE_W-1:0]    sbox_i;
   logic [rc4_pkg::BYTE_W-1:0]    sbox_j;
   logic [63:0]                   cfg_key;
   logic [rc4_pkg::KEY_LEN_W-1:0] cfg_key_len;

   rc4_stream_cipher #(
      .MAX_KEY_BYTES(KEY_BYTES_MAX)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_data_in (req_data_in),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data_out(rsp_data_out),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Cipher prediction
   // ---------------------------------------------------------------------------------

   function automatic void load_identity_sbox();
      for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) sbox[n] = n[rc4_pkg::BYTE_W-1:0];
   endfunction

   // Key schedule: identity, then one swapping pass driven by the cycled key bytes.
   // A length of zero counts as one byte and lengths past the maximum saturate.
   function automatic void run_key_schedule();
      int                         len;
      logic [rc4_pkg::BYTE_W-1:0] acc;
      logic [rc4_pkg::BYTE_W-1:0] key_byte;
      logic [rc4_pkg::BYTE_W-1:0] held;
      len = (cfg_key_len == 0) ? 1 :
            (cfg_key_len > KEY_BYTES_MAX) ? KEY_BYTES_MAX : int'(cfg_key_len);
      load_identity_sbox();
      acc = '0;
      for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) begin
         key_byte = cfg_key[8 * (n % len) +: 8];
         acc      = acc + sbox[n] + key_byte;
         held     = sbox[n];
         sbox[n]  = sbox[acc];
         sbox[acc] = held;
      end
      sbox_i = '0;
      sbox_j = '0;
   endfunction

   // One keystream step: advance both indices, swap, and mask the data byte.
   function automatic logic [rc4_pkg::BYTE_W-1:0] next_cipher_byte(
      logic [rc4_pkg::BYTE_W-1:0] din);
      logic [rc4_pkg::BYTE_W-1:0] held;
      logic [rc4_pkg::BYTE_W-1:0] pick;
      sbox_i       = sbox_i + 8'd1;
      sbox_j       = sbox_j + sbox[sbox_i];
      held         = sbox[sbox_i];
      sbox[sbox_i] = sbox[sbox_j];
      sbox[sbox_j] = held;
      pick         = sbox[sbox_i] + sbox[sbox_j];
      return din ^ sbox[pick];
   endfunction

   // ---------------------------------------------------------------------------------
   // Driver: launches beats from the pending queue at the falling edge. Once a beat is
   // on the bus it stays there, unchanged, until the block takes it.
   // ---------------------------------------------------------------------------------

   always @(negedge clock) begin : beat_driver
      cipher_beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_beats.size() != 0 &&
             (no_gaps || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            beat = pending_beats.pop_front();
            req_valid   <= 1'b1;
            req_kind    <= beat.kind;
            req_data_in <= beat.data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The result side stalls at random, also at the falling edge.
   always @(negedge clock) begin : result_stall
      rsp_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // ---------------------------------------------------------------------------------
   // Monitor: at each rising edge it first checks a returned beat against the oldest
   // predicted byte, then feeds an accepted input beat through the predictor. A byte
   // cannot come back in the cycle its input was taken, so the order is safe.
   // ---------------------------------------------------------------------------------

   always @(posedge clock) begin : beat_monitor
      logic [rc4_pkg::BYTE_W-1:0] want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (cipher_bytes_due.size() == 0) begin
               $error("data_out: no result expected, got %02h", rsp_data_out);
               fail_count++;
            end else begin
               want = cipher_bytes_due.pop_front();
               if (rsp_data_out !== want) begin
                  $error("data_out: expected %02h, got %02h", want, rsp_data_out);
                  fail_count++;
               end
               bytes_checked++;
            end
         end
         if (req_valid && req_ready) begin
            if (req_kind == rc4_pkg::KIND_RESTART) begin
               run_key_schedule();
               restarts_seen++;
            end else begin
               cipher_bytes_due.push_back(next_cipher_byte(req_data_in));
            end
         end
      end
   end

   // A generous watchdog: a run that hangs ends with a failure.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequencing helpers
   // ---------------------------------------------------------------------------------

   function automatic void push_beat(logic kind, logic [rc4_pkg::BYTE_W-1:0] data);
      cipher_beat_type beat;
      beat.kind = kind;
      beat.data = data;
      pending_beats.push_back(beat);
   endfunction

   // Waits until every queued beat is taken and every byte has come back, then lets a
   // possible key schedule run out. This is also where the sender pauses for the block.
   task automatic drain_and_settle();
      while (pending_beats.size() != 0 || req_valid || cipher_bytes_due.size() != 0)
         @(posedge clock);
      repeat (KEY_SCHEDULE_SETTLE) @(posedge clock);
   endtask

   // One write transfer: a setup cycle, then an access cycle held until pready.
   task automatic write_csr(logic reg_idx, logic [rc4_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_idx == rc4_pkg::REG_KEY_BYTES) begin
         cfg_key = value;
      end else begin
         cfg_key_len = value[rc4_pkg::KEY_LEN_W-1:0];
         key_settings++;
      end
   endtask

   // Writes a new key, restarts and sends a couple of data beats.
   task automatic directed_key(logic [63:0] key, logic [rc4_pkg::KEY_LEN_W-1:0] len);
      drain_and_settle();
      write_csr(rc4_pkg::REG_KEY_BYTES, key);
      write_csr(rc4_pkg::REG_KEY_LENGTH, rc4_pkg::CSR_DATA_W'(len));
      push_beat(rc4_pkg::KIND_RESTART, 8'h5A);
      push_beat(rc4_pkg::KIND_DATA, 8'h00);
      push_beat(rc4_pkg::KIND_DATA, 8'hFF);
   endtask

   // A random phase: new key (junk above the length field, which the block must mask),
   // a few beats that carry on the old keystream, a restart, then a long stream of data
   // with an occasional restart in the middle.
   task automatic random_phase(logic [rc4_pkg::KEY_LEN_W-1:0] len, int beats, bit quiet);
      logic [rc4_pkg::CSR_DATA_W-1:0] len_word;
      drain_and_settle();
      no_gaps = quiet;
      write_csr(rc4_pkg::REG_KEY_BYTES, {$urandom(), $urandom()});
      len_word = {$urandom(), $urandom()};
      len_word[rc4_pkg::KEY_LEN_W-1:0] = len;
      write_csr(rc4_pkg::REG_KEY_LENGTH, len_word);
      repeat ($urandom_range(0, 5))
         push_beat(rc4_pkg::KIND_DATA, rc4_pkg::BYTE_W'($urandom()));
      push_beat(rc4_pkg::KIND_RESTART, rc4_pkg::BYTE_W'($urandom()));
      repeat (beats) begin
         if ($urandom_range(0, 99) < 6)
            push_beat(rc4_pkg::KIND_RESTART, rc4_pkg::BYTE_W'($urandom()));
         else
            push_beat(rc4_pkg::KIND_DATA, rc4_pkg::BYTE_W'($urandom()));
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------

   initial begin : stimulus
      logic [rc4_pkg::KEY_LEN_W-1:0] lengths [10];
      load_identity_sbox();
      sbox_i      = '0;
      sbox_j      = '0;
      cfg_key     = '0;
      cfg_key_len = 4'd1;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Data before any restart runs on the reset state, the identity permutation.
      push_beat(rc4_pkg::KIND_DATA, 8'h00);
      push_beat(rc4_pkg::KIND_DATA, 8'hFF);
      push_beat(rc4_pkg::KIND_DATA, 8'h80);
      push_beat(rc4_pkg::KIND_DATA, 8'h01);
      // A restart with the reset key of one zero byte.
      push_beat(rc4_pkg::KIND_RESTART, 8'hFF);
      push_beat(rc4_pkg::KIND_DATA, 8'h00);
      push_beat(rc4_pkg::KIND_DATA, 8'hFF);

      // Length zero counts as one byte; fifteen saturates to the maximum.
      directed_key(64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
      directed_key(64'h0123_4567_89AB_CDEF, 4'd15);
      directed_key({$urandom(), $urandom()}, 4'd8);
      directed_key(64'h0, 4'd1);

      // Random phases walk through every length from one to eight, one past the limit and a random one.
      lengths = '{4'd9, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd1, 4'd0};
      lengths[9] = rc4_pkg::KEY_LEN_W'($urandom_range(0, 15));
      foreach (lengths[p])
         random_phase(lengths[p], 110, p == 4);

      drain_and_settle();

      $display("Checked %0d cipher bytes over %0d key schedules and %0d key lengths,",
               bytes_checked, restarts_seen, key_settings);
      $display("with random stalls on both channels and one gap-free phase.");
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
